/* rtl/core/lfu_pkg.sv */
// lfu_pkg: sizes, codes and shared types of the lfu cache
// used by lfu_if, lfu_cell, lfu_cache_replacement and lfu_checker
`default_nettype none

package lfu_pkg;

	localparam int SLOTS      = 16;
	localparam int COUNT_BITS = 16;
	localparam int KEY_W      = 32;
	localparam int CAP_W      = 5;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RANK_W     = IDX_W;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TOUCH,
		OP_EVICT,
		OP_INSERT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_TOUCH,
		ST_SCAN,
		ST_EVICT,
		ST_INSERT,
		ST_FIN
	} lfu_state_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t                 op;
		logic [RANK_W-1:0]        rank_ref;
		logic [RANK_W-1:0]        new_rank;
		logic                     write_value;
		logic signed [KEY_W-1:0]  key;
		logic signed [KEY_W-1:0]  value;
	} cell_cmd_t;

	// running victim candidate handed down the chain
	typedef struct packed {
		logic                     found;
		logic [COUNT_BITS-1:0]    count;
		logic [RANK_W-1:0]        rank;
		logic [IDX_W-1:0]         idx;
	} best_t;

	// selected cell contents, zero when the cell is not selected
	typedef struct packed {
		logic signed [KEY_W-1:0]  key;
		logic signed [KEY_W-1:0]  value;
		logic [RANK_W-1:0]        rank;
	} cell_rd_t;

endpackage

`default_nettype wire

/* rtl/core/lfu_if.sv */
// lfu_req_if / lfu_rsp_if: valid-ready channels of the lfu cache
// depends on lfu_pkg
`default_nettype none

interface lfu_req_if import lfu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic signed [KEY_W-1:0] key;
	logic signed [KEY_W-1:0] value;

	modport source (output valid, output command, output key, output value, input ready);
	modport sink (input valid, input command, input key, input value, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    hit;
	logic signed [KEY_W-1:0] read_value;
	logic                    evicted;
	logic signed [KEY_W-1:0] evicted_key;

	modport source (output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink (input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface

`default_nettype wire

/* rtl/core/lfu_cell.sv */
// lfu_cell: one cache entry with its use count, recency rank and victim compare stage
// depends on lfu_pkg
`default_nettype none

module lfu_cell import lfu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire cell_cmd_t   cmd,
	input  wire logic        sel,
	input  wire best_t       best_in,
	output best_t            best_out,
	output logic             valid,
	output logic             match,
	output cell_rd_t         rd
);

	logic                    valid_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] value_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [RANK_W-1:0]       rank_q;
	best_t                   best_q;
	logic                    take_mine;
	logic                    dec;

	assign valid = valid_q;
	assign match = valid_q && (key_q == cmd.key);
	assign rd    = sel ? cell_rd_t'{key: key_q, value: value_q, rank: rank_q} : cell_rd_t'('0);

	// this entry beats the candidate from upstream
	assign take_mine = valid_q && (!best_in.found || (count_q < best_in.count) ||
		((count_q == best_in.count) && (rank_q < best_in.rank)));

	// close the rank gap left by a touched or evicted entry
	assign dec = valid_q && (rank_q > cmd.rank_ref) &&
		((cmd.op == OP_TOUCH) || (cmd.op == OP_EVICT));

	assign best_out = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			best_q  <= '0;
		end else begin
			best_q <= take_mine ?
				best_t'{found: 1'b1, count: count_q, rank: rank_q, idx: idx} : best_in;
			if (sel && (cmd.op == OP_EVICT)) begin
				valid_q <= 1'b0;
			end else if (sel && (cmd.op == OP_INSERT)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && (cmd.op == OP_TOUCH)) begin
			rank_q <= cmd.new_rank;
			if (count_q != COUNT_MAX) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
			if (cmd.write_value) begin
				value_q <= cmd.value;
			end
		end else if (sel && (cmd.op == OP_INSERT)) begin
			key_q   <= cmd.key;
			value_q <= cmd.value;
			count_q <= COUNT_BITS'(1);
			rank_q  <= cmd.new_rank;
		end else if (dec) begin
			rank_q <= rank_q - RANK_W'(1);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/lfu_cache_replacement.sv */
// lfu_cache_replacement: lfu key-value cache with lru tie break, row of entry cells
// depends on lfu_pkg, lfu_if and lfu_cell
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-------------------------------------------
//  req     | in  | valid/ready        | command, key, value
//  rsp     | out | valid/ready        | hit, read_value, evicted, evicted_key
//  cfg     | in  | cfg_write (no wait)| cfg_data = capacity
//
//  one request at a time: a get hit, an updating put or a put into a free slot goes
//  from accept through lookup, update and result load; a get miss or a put at
//  capacity zero skips the update; an evicting put scans, evicts, then inserts, and
//  the victim candidate walks the chain one cell per cycle
//  reset clears every valid bit and the entry count and sets capacity to 16
//  a new word is taken while the result register waits; the next result holds until it frees
`default_nettype none

module lfu_cache_replacement import lfu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic [CAP_W-1:0] cfg_data,
	lfu_req_if.sink               req,
	lfu_rsp_if.source             rsp
);

	lfu_state_t              state_q;
	lfu_state_t              state_d;

	// request being served
	logic                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] value_q;

	// working result
	logic                    hit_q;
	logic signed [KEY_W-1:0] rdval_q;
	logic                    evict_q;
	logic signed [KEY_W-1:0] evkey_q;

	// output register
	logic                    rsp_valid_q;
	logic                    rsp_hit_q;
	logic signed [KEY_W-1:0] rsp_rdval_q;
	logic                    rsp_evict_q;
	logic signed [KEY_W-1:0] rsp_evkey_q;

	logic [CAP_W-1:0]        capacity_q;
	logic [CNT_W-1:0]        entry_cnt_q;
	logic [IDX_W-1:0]        scan_cnt_q;
	logic [SLOTS-1:0]        sel_q;        // matching cell, caught in the lookup cycle

	// cell row
	cell_cmd_t               cell_cmd;
	logic [SLOTS-1:0]        sel_vec;
	logic [SLOTS-1:0]        valid_vec;
	logic [SLOTS-1:0]        match_vec;
	logic [SLOTS-1:0]        free_vec;
	logic [SLOTS-1:0]        first_free;
	logic [SLOTS-1:0]        victim_vec;
	best_t                   chain [SLOTS+1];
	cell_rd_t                cell_rd [SLOTS];
	cell_rd_t                rd_or;

	logic [CMP_W-1:0]        cap_eff;
	logic                    cap_zero;
	logic                    full;
	logic                    match_any;
	logic                    load_rsp;
	logic                    scan_done;

	// capacity above the slot count behaves as the slot count
	assign cap_eff   = (CMP_W'(capacity_q) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(capacity_q);
	assign cap_zero  = (cap_eff == '0);
	assign full      = (CMP_W'(entry_cnt_q) >= cap_eff);
	assign match_any = |match_vec;
	assign scan_done = (scan_cnt_q == IDX_W'(SLOTS - 1));
	assign load_rsp  = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	// lowest free slot, one-hot
	assign free_vec   = ~valid_vec;
	assign first_free = free_vec & (~free_vec + SLOTS'(1));

	// victim from the end of the chain, one-hot
	always_comb begin
		victim_vec = '0;
		victim_vec[chain[SLOTS].idx] = chain[SLOTS].found;
	end

	// the selected cell drives its contents, the rest drive zero
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < SLOTS; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		lfu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.cmd      (cell_cmd),
			.sel      (sel_vec[i]),
			.best_in  (chain[i]),
			.best_out (chain[i+1]),
			.valid    (valid_vec[i]),
			.match    (match_vec[i]),
			.rd       (cell_rd[i])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and cell commands
	always_comb begin
		state_d              = state_q;
		req.ready            = 1'b0;
		sel_vec              = '0;
		cell_cmd.op          = OP_NONE;
		cell_cmd.rank_ref    = rd_or.rank;
		cell_cmd.new_rank    = RANK_W'(entry_cnt_q);
		cell_cmd.write_value = (cmd_q == CMD_PUT);
		cell_cmd.key         = key_q;
		cell_cmd.value       = value_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (cmd_q == CMD_GET) begin
					state_d = match_any ? ST_TOUCH : ST_FIN;
				end else if (cap_zero) begin
					state_d = ST_FIN;
				end else if (match_any) begin
					state_d = ST_TOUCH;
				end else if (full) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_TOUCH: begin
				// touched entry becomes the most recent
				sel_vec           = sel_q;
				cell_cmd.op       = OP_TOUCH;
				cell_cmd.new_rank = RANK_W'(entry_cnt_q - CNT_W'(1));
				state_d           = ST_FIN;
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				sel_vec     = victim_vec;
				cell_cmd.op = OP_EVICT;
				state_d     = ST_INSERT;
			end
			ST_INSERT: begin
				sel_vec     = first_free;
				cell_cmd.op = OP_INSERT;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (load_rsp) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			entry_cnt_q <= '0;
			scan_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				capacity_q <= cfg_data;
			end
			if (state_q == ST_EVICT) begin
				entry_cnt_q <= entry_cnt_q - CNT_W'(1);
			end else if (state_q == ST_INSERT) begin
				entry_cnt_q <= entry_cnt_q + CNT_W'(1);
			end
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end else begin
				scan_cnt_q <= '0;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q   <= req.command;
			key_q   <= req.key;
			value_q <= req.value;
			hit_q   <= 1'b0;
			rdval_q <= '1;
			evict_q <= 1'b0;
			evkey_q <= '0;
		end
		if (state_q == ST_LOOK) begin
			sel_q <= match_vec;
			// a put with capacity zero reports a miss even on a stored key
			hit_q <= match_any && !((cmd_q == CMD_PUT) && cap_zero);
		end
		if ((state_q == ST_TOUCH) && (cmd_q == CMD_GET)) begin
			rdval_q <= rd_or.value;
		end
		if (state_q == ST_EVICT) begin
			evict_q <= 1'b1;
			evkey_q <= rd_or.key;
		end
		if (load_rsp) begin
			rsp_hit_q   <= hit_q;
			rsp_rdval_q <= rdval_q;
			rsp_evict_q <= evict_q;
			rsp_evkey_q <= evkey_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_rdval_q;
	assign rsp.evicted     = rsp_evict_q;
	assign rsp.evicted_key = rsp_evkey_q;

endmodule

`default_nettype wire

/* rtl/core/lfu_checker.sv */
// lfu_checker: port-level assertions for lfu_cache_replacement, bound to the top level
// depends on lfu_pkg
`default_nettype none

module lfu_checker import lfu_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    req_valid,
	input wire logic                    req_ready,
	input wire logic                    rsp_valid,
	input wire logic                    rsp_ready,
	input wire logic                    rsp_hit,
	input wire logic signed [KEY_W-1:0] rsp_read_value,
	input wire logic                    rsp_evicted,
	input wire logic signed [KEY_W-1:0] rsp_evicted_key
);

	// a stalled result stays valid and keeps its hit flag and evicted key
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_evicted_key) && $stable(rsp_hit))
		else $error("result word changed while stalled");

	// one request in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second word taken while a request is in work");

	// an eviction only comes from a put of a new key
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_evicted |-> !rsp_hit && (rsp_read_value == -32'sd1))
		else $error("eviction reported with a hit or a read value");

	// no evicted key without an eviction
	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted |-> (rsp_evicted_key == '0))
		else $error("evicted key set without an eviction");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_hit         (rsp.hit),
	.rsp_read_value  (rsp.read_value),
	.rsp_evicted     (rsp.evicted),
	.rsp_evicted_key (rsp.evicted_key)
);

`default_nettype wire
